// ===== hw/rtl/prco_pkg.sv =====
package prco_pkg;

   localparam int unsigned TS_BITS        = 32;
   localparam int unsigned FIELD_BITS     = 16;
   localparam int unsigned QUO_BITS       = 17;
   localparam int unsigned HALF_ROOT2_Q14 = 11585;

   localparam logic [15:0] WALL_RADIUS_RST  = 16'd2582;
   localparam logic [15:0] ROTATION_COS_RST = 16'd15137;
   localparam logic [15:0] ROTATION_SIN_RST = 16'd6270;

   localparam logic [16:0] POS_LIMIT = 17'd32767;
   localparam logic [16:0] NEG_LIMIT = 17'd32768;

   typedef enum logic [1:0] {
      CSR_WALL_RADIUS  = 2'd0,
      CSR_ROTATION_COS = 2'd1,
      CSR_ROTATION_SIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        timestamp;
      logic signed [15:0] probe_0;
      logic signed [15:0] probe_45;
      logic signed [15:0] probe_90;
      logic signed [15:0] probe_135;
      logic signed [15:0] probe_180;
      logic signed [15:0] probe_225;
      logic signed [15:0] probe_270;
      logic signed [15:0] probe_315;
   } req_type;

   typedef struct packed {
      logic [31:0]        time_out;
      logic signed [15:0] x_offset;
      logic signed [15:0] y_offset;
      logic               invalid;
      logic               saturated;
   } rsp_type;

   // sideband that rides along the pipeline next to the arithmetic
   typedef struct packed {
      logic        vld;
      logic [31:0] ts;
      logic        inv;
   } side_type;

endpackage

// ===== hw/rtl/prco_div.sv =====
// Restoring divider, one quotient bit per stage, magnitude only.
module prco_div
   import prco_pkg::*;
#(
   parameter int NW = 40,
   parameter int DW = 19
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic          neg,
   output logic [QUO_BITS-1:0] quo,
   output logic          ovf,
   output logic          neg_out
);

   localparam int QW = QUO_BITS;
   localparam int HW = NW - QW;

   logic [DW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] lo_ff  [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          ovf_ff [QW+1];
   logic          neg_ff [QW+1];

   logic [HW-1:0] hi;
   logic          ovf_in;

   assign hi     = num[NW-1:QW];
   assign ovf_in = hi >= HW'(den);

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= hi[DW-1:0];
         den_ff[0] <= den;
         lo_ff[0]  <= num[QW-1:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= neg;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [DW:0] trial_in;
      logic [DW:0] diff_in;
      logic        ge_in;

      assign trial_in = {rem_ff[j], lo_ff[j][QW-1-j]};
      assign ge_in    = trial_in >= {1'b0, den_ff[j]};
      assign diff_in  = trial_in - {1'b0, den_ff[j]};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j+1] <= ge_in ? diff_in[DW-1:0] : trial_in[DW-1:0];
            q_ff[j+1]   <= {q_ff[j][QW-2:0], ge_in};
            den_ff[j+1] <= den_ff[j];
            lo_ff[j+1]  <= lo_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
      end
   end

   assign quo     = q_ff[QW];
   assign ovf     = ovf_ff[QW];
   assign neg_out = neg_ff[QW];

endmodule

// ===== hw/rtl/prco_front.sv =====
// Sum, first harmonic, rotation, scaling and numerator prep: six stages.
module prco_front
   import prco_pkg::*;
#(
   parameter int SB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  req_type              in_data,
   input  logic [15:0]          wall_radius,
   input  logic signed [15:0]   rot_cos,
   input  logic signed [15:0]   rot_sin,
   output side_type             side,
   output logic [SB+2:0]        x0,
   output logic [SB+23:0]       num_x,
   output logic [SB+23:0]       num_y,
   output logic                 neg_x,
   output logic                 neg_y
);

   localparam int XW = SB + 3;
   localparam int RW = SB + 17;
   localparam int PW = RW + 16;
   localparam int SW = PW + 1;
   localparam int AW = SW - 13;
   localparam int MW = AW + 16;
   localparam int NW = MW - 13;

   localparam logic signed [RW-1:0] K_HALF = RW'(HALF_ROOT2_Q14);

   side_type side1_ff, side2_ff, side3_ff, side4_ff, side5_ff, side6_ff;

   // stage 1: samples, sum and butterflies
   logic signed [SB-1:0] p_in [8];
   logic [FIELD_BITS-1:0] field_in [8];
   logic signed [XW-1:0] x0_in;
   logic signed [SB:0]   a_in, e_in;
   logic signed [SB+1:0] b_in, f_in;
   logic signed [XW-1:0] x0_1_ff;
   logic signed [SB:0]   a_ff, e_ff;
   logic signed [SB+1:0] b_ff, f_ff;
   side_type             side1_in;

   assign field_in[0] = in_data.probe_0;
   assign field_in[1] = in_data.probe_45;
   assign field_in[2] = in_data.probe_90;
   assign field_in[3] = in_data.probe_135;
   assign field_in[4] = in_data.probe_180;
   assign field_in[5] = in_data.probe_225;
   assign field_in[6] = in_data.probe_270;
   assign field_in[7] = in_data.probe_315;

   for (genvar k = 0; k < 8; k++) begin : g_samp
      logic [SB+FIELD_BITS-1:0] wide;
      assign wide    = {{SB{1'b0}}, field_in[k]};
      assign p_in[k] = $signed(wide[SB-1:0]);
   end

   assign x0_in = XW'(p_in[0]) + XW'(p_in[1]) + XW'(p_in[2]) + XW'(p_in[3])
                + XW'(p_in[4]) + XW'(p_in[5]) + XW'(p_in[6]) + XW'(p_in[7]);
   assign a_in  = (SB+1)'(p_in[0]) - (SB+1)'(p_in[4]);
   assign e_in  = (SB+1)'(p_in[2]) - (SB+1)'(p_in[6]);
   assign b_in  = (SB+2)'(p_in[1]) - (SB+2)'(p_in[3]) - (SB+2)'(p_in[5])
                + (SB+2)'(p_in[7]);
   assign f_in  = (SB+2)'(p_in[1]) + (SB+2)'(p_in[3]) - (SB+2)'(p_in[5])
                - (SB+2)'(p_in[7]);

   always_comb begin
      side1_in.vld = in_valid;
      side1_in.ts  = in_data.timestamp;
      side1_in.inv = x0_in <= 0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_1_ff <= x0_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
         e_ff    <= e_in;
         f_ff    <= f_in;
      end
   end

   // stage 2: harmonic in Q.14
   logic signed [RW-1:0] r_in, i_in, r_ff, i_ff;
   logic signed [XW-1:0] x0_2_ff;

   assign r_in = (RW'(a_ff) <<< 14) + RW'(b_ff) * K_HALF;
   assign i_in = -((RW'(e_ff) <<< 14) + RW'(f_ff) * K_HALF);

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff    <= r_in;
         i_ff    <= i_in;
         x0_2_ff <= x0_1_ff;
      end
   end

   // stage 3: rotation products
   logic signed [PW-1:0] rc_in, is_in, rs_in, ic_in;
   logic signed [PW-1:0] rc_ff, is_ff, rs_ff, ic_ff;
   logic signed [XW-1:0] x0_3_ff;

   assign rc_in = r_ff * rot_cos;
   assign is_in = i_ff * rot_sin;
   assign rs_in = r_ff * rot_sin;
   assign ic_in = i_ff * rot_cos;

   always_ff @(posedge clock) begin
      if (advance) begin
         rc_ff   <= rc_in;
         is_ff   <= is_in;
         rs_ff   <= rs_in;
         ic_ff   <= ic_in;
         x0_3_ff <= x0_2_ff;
      end
   end

   // stage 4: sums, rounded back to Q.14 as sign and magnitude
   logic signed [SW-1:0] ax_in, ay_in;
   logic [SW-1:0]        max_in, may_in;
   logic [SW:0]          rx_in, ry_in;
   logic [AW-1:0]        magx_ff, magy_ff;
   logic                 negx4_ff, negy4_ff;
   logic signed [XW-1:0] x0_4_ff;

   assign ax_in  = SW'(rc_ff) + SW'(is_ff);
   assign ay_in  = SW'(rs_ff) - SW'(ic_ff);
   assign max_in = ax_in[SW-1] ? SW'(-ax_in) : SW'(ax_in);
   assign may_in = ay_in[SW-1] ? SW'(-ay_in) : SW'(ay_in);
   assign rx_in  = ({1'b0, max_in} + (SW+1)'(8192)) >> 14;
   assign ry_in  = ({1'b0, may_in} + (SW+1)'(8192)) >> 14;

   always_ff @(posedge clock) begin
      if (advance) begin
         magx_ff  <= rx_in[AW-1:0];
         magy_ff  <= ry_in[AW-1:0];
         negx4_ff <= ax_in[SW-1];
         negy4_ff <= ay_in[SW-1];
         x0_4_ff  <= x0_3_ff;
      end
   end

   // stage 5: radius scaling
   logic [MW-1:0]        px_ff, py_ff;
   logic                 negx5_ff, negy5_ff;
   logic signed [XW-1:0] x0_5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff    <= MW'(magx_ff) * MW'(wall_radius);
         py_ff    <= MW'(magy_ff) * MW'(wall_radius);
         negx5_ff <= negx4_ff;
         negy5_ff <= negy4_ff;
         x0_5_ff  <= x0_4_ff;
      end
   end

   // stage 6: fold the rounding half-divisor in and drop the Q.14 of the divisor
   logic [MW:0]   sx_in, sy_in, half_in;
   logic [NW-1:0] nx_ff, ny_ff;
   logic          negx6_ff, negy6_ff;
   logic [XW-1:0] x0_6_ff;

   assign half_in = (MW+1)'(unsigned'(x0_5_ff)) << 13;
   assign sx_in   = {1'b0, px_ff} + half_in;
   assign sy_in   = {1'b0, py_ff} + half_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff    <= sx_in[MW:14];
         ny_ff    <= sy_in[MW:14];
         negx6_ff <= negx5_ff;
         negy6_ff <= negy5_ff;
         x0_6_ff  <= unsigned'(x0_5_ff);
      end
   end

   // sideband
   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.vld <= 1'b0;
         side2_ff.vld <= 1'b0;
         side3_ff.vld <= 1'b0;
         side4_ff.vld <= 1'b0;
         side5_ff.vld <= 1'b0;
         side6_ff.vld <= 1'b0;
      end else if (advance) begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
         side5_ff <= side4_ff;
         side6_ff <= side5_ff;
      end
   end

   assign side  = side6_ff;
   assign x0    = x0_6_ff;
   assign num_x = nx_ff;
   assign num_y = ny_ff;
   assign neg_x = negx6_ff;
   assign neg_y = negy6_ff;

endmodule

// ===== hw/rtl/probe_ring_centroid_offset.sv =====
// Channel | Direction | Handshake          | Beat
// req     | in        | req_valid/req_stall | req_data: timestamp, eight probe samples
// rsp     | out       | rsp_valid/rsp_stall | rsp_data: time_out, offsets, flags
// csr     | in        | csr_we              | csr_index, csr_wdata
//
// One beat per cycle sustained while the output is not stalled; a beat passes six
// arithmetic stages, an 18 stage divider (input register, then one quotient bit per
// stage) and the output register.
// Synchronous active-high reset clears valid bits and the registers to defaults.
// The whole pipe holds when a finished beat sits in the output register and
// rsp_stall is high; req_stall is raised in exactly those cycles.
module probe_ring_centroid_offset
   import prco_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SB = SAMPLE_BITS;
   localparam int XW = SB + 3;
   localparam int NW = SB + 24;
   localparam int QW = QUO_BITS;

   logic [15:0] wall_ff, cos_ff, sin_ff;
   logic        advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_ff <= WALL_RADIUS_RST;
         cos_ff  <= ROTATION_COS_RST;
         sin_ff  <= ROTATION_SIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WALL_RADIUS:  wall_ff <= csr_wdata;
            CSR_ROTATION_COS: cos_ff  <= csr_wdata;
            CSR_ROTATION_SIN: sin_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   side_type      side_f;
   logic [XW-1:0] x0;
   logic [NW-1:0] num_x, num_y;
   logic          neg_x, neg_y;

   prco_front #(.SB(SB)) u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_data     (req_data),
      .wall_radius (wall_ff),
      .rot_cos     ($signed(cos_ff)),
      .rot_sin     ($signed(sin_ff)),
      .side        (side_f),
      .x0          (x0),
      .num_x       (num_x),
      .num_y       (num_y),
      .neg_x       (neg_x),
      .neg_y       (neg_y)
   );

   logic [QW-1:0] qx, qy;
   logic          ovf_x, ovf_y, nx_o, ny_o;

   prco_div #(.NW(NW), .DW(XW)) u_div_x (
      .clock (clock), .advance (advance), .num (num_x), .den (x0), .neg (neg_x),
      .quo (qx), .ovf (ovf_x), .neg_out (nx_o)
   );

   prco_div #(.NW(NW), .DW(XW)) u_div_y (
      .clock (clock), .advance (advance), .num (num_y), .den (x0), .neg (neg_y),
      .quo (qy), .ovf (ovf_y), .neg_out (ny_o)
   );

   // sideband delay matching the divider
   side_type side_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) begin
            side_ff[j].vld <= 1'b0;
         end
      end else if (advance) begin
         side_ff[0] <= side_f;
         for (int j = 1; j <= QW; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // clip and sign
   logic        satx_in, saty_in;
   logic [15:0] vx_in, vy_in;
   rsp_type     rsp_in;

   always_comb begin
      if (nx_o) begin
         satx_in = ovf_x || (qx > NEG_LIMIT);
         vx_in   = satx_in ? 16'h8000 : 16'(-qx);
      end else begin
         satx_in = ovf_x || (qx > POS_LIMIT);
         vx_in   = satx_in ? 16'h7fff : qx[15:0];
      end
      if (ny_o) begin
         saty_in = ovf_y || (qy > NEG_LIMIT);
         vy_in   = saty_in ? 16'h8000 : 16'(-qy);
      end else begin
         saty_in = ovf_y || (qy > POS_LIMIT);
         vy_in   = saty_in ? 16'h7fff : qy[15:0];
      end
      rsp_in.time_out = side_ff[QW].ts;
      rsp_in.invalid  = side_ff[QW].inv;
      if (side_ff[QW].inv) begin
         rsp_in.x_offset  = '0;
         rsp_in.y_offset  = '0;
         rsp_in.saturated = 1'b0;
      end else begin
         rsp_in.x_offset  = $signed(vx_in);
         rsp_in.y_offset  = $signed(vy_in);
         rsp_in.saturated = satx_in || saty_in;
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= side_ff[QW].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.invalid |->
         rsp_data_ff.x_offset == 0 && rsp_data_ff.y_offset == 0 &&
         !rsp_data_ff.saturated)
      else $error("invalid beat with nonzero offsets");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while output held");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.saturated |->
         rsp_data_ff.x_offset == 16'sh7fff || rsp_data_ff.x_offset == -16'sh8000 ||
         rsp_data_ff.y_offset == 16'sh7fff || rsp_data_ff.y_offset == -16'sh8000)
      else $error("saturated flag without clipped offset");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("output valid right after reset");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import prco_pkg::*;

   localparam int LATENCY = 25;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   probe_ring_centroid_offset dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers
   logic [15:0] ring_radius;
   logic [15:0] rot_cos;
   logic [15:0] rot_sin;

   rsp_type offset_queue[$];
   int      mismatches;
   int      slices_sent;
   int      offsets_seen;
   int      invalid_seen;
   int      clipped_seen;
   longint  cycles;
   bit      quiet;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d offsets outstanding", cycles,
                  offset_queue.size());
         $display("probe_ring_centroid_offset verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint round_q14(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + 8192) >>> 14;
      return (v < 0) ? -m : m;
   endfunction

   function automatic logic [15:0] clip_quotient(longint num, longint den, inout bit sat);
      longint m;
      longint q;
      m = (num < 0) ? -num : num;
      q = (2 * m + den) / (2 * den);
      if (num < 0) begin
         if (q > 32768) begin
            sat = 1'b1;
            q = 32768;
         end
         q = -q;
      end else if (q > 32767) begin
         sat = 1'b1;
         q = 32767;
      end
      return q[15:0];
   endfunction

   function automatic rsp_type predict_offset(req_type s);
      rsp_type o;
      longint  p0, p45, p90, p135, p180, p225, p270, p315;
      longint  sum, re, im, c, sn, ax, ay;
      bit      sat;
      p0 = s.probe_0;     p45 = s.probe_45;   p90 = s.probe_90;   p135 = s.probe_135;
      p180 = s.probe_180; p225 = s.probe_225; p270 = s.probe_270; p315 = s.probe_315;
      sum = p0 + p45 + p90 + p135 + p180 + p225 + p270 + p315;
      o = '0;
      o.time_out = s.timestamp;
      if (sum <= 0) begin
         o.invalid = 1'b1;
         return o;
      end
      re = (p0 - p180) * 16384 + (p45 - p135 - p225 + p315) * HALF_ROOT2_Q14;
      im = -((p90 - p270) * 16384 + (p45 + p135 - p225 - p315) * HALF_ROOT2_Q14);
      c = longint'($signed(rot_cos));
      sn = longint'($signed(rot_sin));
      ax = round_q14(re * c + im * sn);
      ay = round_q14(re * sn - im * c);
      sat = 1'b0;
      o.x_offset = clip_quotient(longint'(ring_radius) * ax, sum * 16384, sat);
      o.y_offset = clip_quotient(longint'(ring_radius) * ay, sum * 16384, sat);
      o.saturated = sat;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // result side: random stall, checks every beat against the oldest prediction
   int stall_left;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            offsets_seen++;
            if (offset_queue.size() == 0) begin
               report_mismatch("unexpected beat, time_out", rsp_data.time_out, -1);
            end else begin
               want = offset_queue.pop_front();
               if (rsp_data.invalid) invalid_seen++;
               if (rsp_data.saturated) clipped_seen++;
               if (rsp_data.time_out !== want.time_out)
                  report_mismatch("time_out", rsp_data.time_out, want.time_out);
               if (rsp_data.x_offset !== want.x_offset)
                  report_mismatch("x_offset", rsp_data.x_offset, want.x_offset);
               if (rsp_data.y_offset !== want.y_offset)
                  report_mismatch("y_offset", rsp_data.y_offset, want.y_offset);
               if (rsp_data.invalid !== want.invalid)
                  report_mismatch("invalid", rsp_data.invalid, want.invalid);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_data.saturated, want.saturated);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_left <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_slice(input req_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
      offset_queue.push_back(predict_offset(s));
      slices_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (offset_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_WALL_RADIUS:  ring_radius = value;
         CSR_ROTATION_COS: rot_cos = value;
         CSR_ROTATION_SIN: rot_sin = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] w, input logic [15:0] c, input logic [15:0] s);
      write_reg(CSR_WALL_RADIUS, w);
      write_reg(CSR_ROTATION_COS, c);
      write_reg(CSR_ROTATION_SIN, s);
      // spare index must not disturb anything
      write_reg(CSR_SPARE, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic req_type uniform_slice(input logic signed [15:0] v);
      req_type s;
      s.timestamp = $urandom;
      {s.probe_0, s.probe_45, s.probe_90, s.probe_135} = {4{v}};
      {s.probe_180, s.probe_225, s.probe_270, s.probe_315} = {4{v}};
      return s;
   endfunction

   function automatic req_type random_slice();
      req_type s;
      int      kind, base, spread;
      logic signed [15:0] p[8];
      kind = $urandom_range(0, 99);
      base = $urandom_range(0, 8000);
      spread = $urandom_range(0, 2) == 0 ? 32767 : $urandom_range(1, 3000);
      for (int k = 0; k < 8; k++) begin
         if (kind < 20) p[k] = 16'($urandom);
         else if (kind < 35) p[k] = 16'($urandom_range(0, 64)) - 16'sd20;
         else p[k] = 16'(base + $signed($urandom_range(0, 2 * spread)) - spread);
      end
      s.timestamp = $urandom;
      {s.probe_0, s.probe_45, s.probe_90, s.probe_135} = {p[0], p[1], p[2], p[3]};
      {s.probe_180, s.probe_225, s.probe_270, s.probe_315} = {p[4], p[5], p[6], p[7]};
      return s;
   endfunction

   task automatic test_directed();
      req_type s;
      quiet = 1'b1;
      send_slice(uniform_slice(16'sh7fff));
      send_slice(uniform_slice(-16'sh8000));
      send_slice(uniform_slice(16'sd0));
      send_slice(uniform_slice(16'sd1));
      // one lone probe per slice, from tiny to full-scale values
      for (int k = 0; k < 8; k++) begin
         s = uniform_slice(16'sd0);
         s.timestamp = (k == 0) ? 32'h0 : (k == 1) ? 32'hffff_ffff : s.timestamp;
         case (k)
            0: s.probe_0 = 16'sd1;
            1: s.probe_45 = 16'sh7fff;
            2: s.probe_90 = 16'sd3;
            3: s.probe_135 = 16'sd200;
            4: s.probe_180 = 16'sd1;
            5: s.probe_225 = 16'sh7fff;
            6: s.probe_270 = 16'sd7;
            default: s.probe_315 = 16'sd2;
         endcase
         send_slice(s);
      end
      s = uniform_slice(16'sh7fff);
      s.probe_180 = -16'sh8000;
      send_slice(s);
      s = uniform_slice(-16'sh8000);
      s.probe_0 = 16'sh7fff;
      send_slice(s);
      s = uniform_slice(16'sd1000);
      s.probe_90 = 16'sd1100;
      s.probe_270 = 16'sd900;
      send_slice(s);
      quiet = 1'b0;
      drain();
   endtask

   task automatic test_config_phase(input logic [15:0] w, input logic [15:0] c,
                                    input logic [15:0] s, input int count);
      configure(w, c, s);
      if (($urandom_range(0, 3)) == 0) quiet = 1'b1;
      for (int i = 0; i < count; i++) send_slice(random_slice());
      quiet = 1'b0;
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_WALL_RADIUS;
      csr_wdata <= '0;
      cycles = 0;
      quiet = 1'b0;
      ring_radius = WALL_RADIUS_RST;
      rot_cos = ROTATION_COS_RST;
      rot_sin = ROTATION_SIN_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config_phase(WALL_RADIUS_RST, ROTATION_COS_RST, ROTATION_SIN_RST, 240);
      test_config_phase(16'd0, 16'sd16384, 16'sd0, 200);
      test_config_phase(16'd65535, -16'sd16384, 16'sd0, 240);
      test_config_phase(16'd256, 16'sd0, 16'sd16384, 240);
      test_config_phase(16'd65535, 16'sd0, -16'sd16384, 240);
      test_config_phase(16'd1, -16'sd16384, -16'sd16384, 200);
      test_config_phase(16'($urandom), 16'($urandom), 16'($urandom), 240);
      test_config_phase(16'd2582, 16'sd11585, -16'sd11585, 240);

      $display("%0d slices through %0d register settings; %0d offsets checked",
               slices_sent, 8, offsets_seen);
      $display("%0d flagged invalid, %0d clipped, %0d mismatches",
               invalid_seen, clipped_seen, mismatches);
      if (mismatches == 0 && offset_queue.size() == 0) begin
         $display("probe_ring_centroid_offset verification clean");
      end else begin
         $display("probe_ring_centroid_offset verification failed");
      end
      $finish;
   end

endmodule
